[sv/cms_pkg.sv]
// Shared types and constants of the RGB min-max contrast stretch.
// No dependencies; every other file of the block depends on this package.
package cms_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChIdxW  = 2;
  localparam int unsigned DvdW    = 2 * ChanW;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ChanW-1:0] ChanFull = {ChanW{1'b1}};
  localparam logic [ChanW-1:0] ChanZero = '0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTargetLow  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetHigh = 1'd1;

  // input opcodes
  localparam logic OpGather    = 1'b0;
  localparam logic OpTransform = 1'b1;

  localparam logic [ChIdxW-1:0] LastChan = ChIdxW'(NumChan - 1);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StLoad
  } cms_state_e;

  typedef struct packed {
    logic             start;
    logic [DvdW-1:0]  dividend;
    logic [ChanW-1:0] divisor;
  } cms_div_req_t;

  typedef struct packed {
    logic             done;
    logic [ChanW-1:0] quot;
  } cms_div_rsp_t;

endpackage

[sv/cms_if.sv]
// Valid/ready channel interfaces for pixel items and stretched results.
// Depends on cms_pkg for the channel width.
interface cms_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic                      frame_start;
  logic [cms_pkg::ChanW-1:0] red_in;
  logic [cms_pkg::ChanW-1:0] green_in;
  logic [cms_pkg::ChanW-1:0] blue_in;

  modport source (output valid, opcode, frame_start, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, opcode, frame_start, red_in, green_in, blue_in,
                output ready);
endinterface

interface cms_res_if;
  logic                      valid;
  logic                      ready;
  logic [cms_pkg::ChanW-1:0] red_out;
  logic [cms_pkg::ChanW-1:0] green_out;
  logic [cms_pkg::ChanW-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

[sv/cms_div.sv]
// Bit-serial restoring divider: unsigned 16-bit dividend by 8-bit divisor.
// Returns the low byte of the quotient. Depends on cms_pkg.
module cms_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cms_pkg::cms_div_req_t req_i,
  output cms_pkg::cms_div_rsp_t rsp_o
);
  import cms_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [ChanW-1:0] rem_q, rem_d;
  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [ChanW-1:0] dsr_q;
  logic [ChanW:0]   rem_sh;
  logic [ChanW:0]   rem_sub;
  logic             ge;

  // one quotient bit per cycle, MSB first
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[ChanW-1:0] : rem_sh[ChanW-1:0];
    dvd_d   = {dvd_q[DvdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(DvdW - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q[ChanW-1:0];

endmodule

[sv/rgb_min_max_contrast_stretch.sv]
// Per-channel min-max contrast stretch of RGB pixels; top level.
// Gather item: transferred with no result; ready again next cycle.
// Transform item: per channel a multiply step, 16 divider steps and a finish step, channels
// in turn through one shared divider, then a load step into the result register; the next
// item is taken once the load is done (a flat channel skips the divider; an untaken result
// holds the load). Reset (async, active low): min 255, max 0, targets 0 and 255, no output.
module rgb_min_max_contrast_stretch (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cms_pix_if.sink                     pix_i,
  cms_res_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [cms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cms_pkg::ChanW-1:0]   cfg_data_i
);
  import cms_pkg::*;

  cms_state_e state_q, state_d;

  // per-channel statistics, index 0 red, 1 green, 2 blue
  logic [ChanW-1:0] min_q [NumChan];
  logic [ChanW-1:0] max_q [NumChan];
  logic [ChanW-1:0] pix_q [NumChan];
  logic [ChanW-1:0] res_q [NumChan];
  logic [ChanW-1:0] in_v  [NumChan];

  logic [ChanW-1:0] tgt_lo_q, tgt_hi_q;
  logic [ChIdxW-1:0] ch_q;
  logic             neg_q;

  logic             out_valid_q;
  logic [ChanW-1:0] out_r_q, out_g_q, out_b_q;

  logic in_xfer, out_xfer;
  logic load_out;

  cms_div_req_t div_req;
  cms_div_rsp_t div_rsp;

  // selected channel arithmetic for the multiply step
  logic signed [ChanW:0]     diff_s, span_s, scale_s;
  logic signed [2*ChanW+1:0] prod_s;
  logic [2*ChanW+1:0]        prod_abs;
  logic [ChanW:0]            span_abs;
  logic                      span_zero;
  logic [ChanW-1:0]          quot_fix;

  assign in_v[0] = pix_i.red_in;
  assign in_v[1] = pix_i.green_in;
  assign in_v[2] = pix_i.blue_in;

  assign in_xfer  = pix_i.valid && pix_i.ready;
  assign out_xfer = res_o.valid && res_o.ready;

  always_comb begin
    diff_s    = $signed({1'b0, pix_q[ch_q]}) - $signed({1'b0, min_q[ch_q]});
    span_s    = $signed({1'b0, max_q[ch_q]}) - $signed({1'b0, min_q[ch_q]});
    scale_s   = $signed({1'b0, tgt_hi_q}) - $signed({1'b0, tgt_lo_q});
    prod_s    = (2*ChanW+2)'(diff_s) * (2*ChanW+2)'(scale_s);
    prod_abs  = prod_s[2*ChanW+1] ? (2*ChanW+2)'(-prod_s) : prod_s;
    span_abs  = span_s[ChanW] ? (ChanW+1)'(-span_s) : span_s;
    span_zero = span_s == '0;
    // truncation toward zero: negate the magnitude quotient, keep low byte
    quot_fix  = (neg_q ? (~div_rsp.quot + ChanW'(1)) : div_rsp.quot) + tgt_lo_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer && (pix_i.opcode == OpTransform)) state_d = StMul;
      end
      StMul: begin
        if (span_zero) begin
          state_d = (ch_q == LastChan) ? StLoad : StMul;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) state_d = (ch_q == LastChan) ? StLoad : StMul;
      end
      StLoad: begin
        if (!out_valid_q || res_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    pix_i.ready      = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_abs[DvdW-1:0];
    div_req.divisor  = span_abs[ChanW-1:0];
    unique case (state_q)
      StIdle: pix_i.ready   = 1'b1;
      StMul:  div_req.start = !span_zero;
      StDiv:  ;
      StLoad: load_out      = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  cms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control state, statistics and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      tgt_lo_q    <= ChanZero;
      tgt_hi_q    <= ChanFull;
      for (int i = 0; i < NumChan; i++) begin
        min_q[i] <= ChanFull;
        max_q[i] <= ChanZero;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTargetLow:  tgt_lo_q <= cfg_data_i;
          CfgTargetHigh: tgt_hi_q <= cfg_data_i;
          default: ;
        endcase
      end

      // gather: fold the pixel into the running extremes, restart on frame start
      if (in_xfer && (pix_i.opcode == OpGather)) begin
        for (int i = 0; i < NumChan; i++) begin
          if (pix_i.frame_start) begin
            min_q[i] <= in_v[i];
            max_q[i] <= in_v[i];
          end else begin
            if (in_v[i] < min_q[i]) min_q[i] <= in_v[i];
            if (in_v[i] > max_q[i]) max_q[i] <= in_v[i];
          end
        end
      end

      // advance the channel pointer after each finished channel
      if (in_xfer) begin
        ch_q <= '0;
      end else if ((state_q == StMul && span_zero) || (state_q == StDiv && div_rsp.done)) begin
        ch_q <= (ch_q == LastChan) ? '0 : ch_q + ChIdxW'(1);
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < NumChan; i++) pix_q[i] <= in_v[i];
    end
    if (state_q == StMul) begin
      neg_q <= prod_s[2*ChanW+1] ^ span_s[ChanW];
      if (span_zero) res_q[ch_q] <= pix_q[ch_q];
    end
    if (state_q == StDiv && div_rsp.done) begin
      res_q[ch_q] <= quot_fix;
    end
    if (load_out) begin
      out_r_q <= res_q[0];
      out_g_q <= res_q[1];
      out_b_q <= res_q[2];
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.red_out   = out_r_q;
  assign res_o.green_out = out_g_q;
  assign res_o.blue_out  = out_b_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the RGB min-max contrast stretch.
// Depends on cms_pkg, the cms_pix_if and cms_res_if interfaces and the
// rgb_min_max_contrast_stretch top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cms_pkg::*;

  // one pixel as three channel samples: index 0 is red, 1 green, 2 blue
  typedef logic [0:NumChan-1][ChanW-1:0] rgb_t;

  typedef enum logic {
    RowPixel,
    RowWrite
  } row_kind_e;

  // one line of the directed table: either a pixel transfer or a register write
  typedef struct packed {
    row_kind_e          kind;
    logic               op;
    logic               fs;
    rgb_t               px;
    logic               known;
    rgb_t               want;
    logic [CfgIdxW-1:0] idx;
    logic [ChanW-1:0]   val;
  } stim_row_t;

  localparam int unsigned NumDirected = 22;
  localparam int unsigned RandomItems = 1750;
  // wait after the last owed result before a register write or the end
  localparam int unsigned DrainCycles = 64;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ChanW-1:0] cfg_data_i;

  cms_pix_if pix ();
  cms_res_if res ();

  rgb_t stretched_q [$];         // stretched pixels still owed by the block
  rgb_t chan_lo = {NumChan{ChanFull}};
  rgb_t chan_hi = {NumChan{ChanZero}};
  logic [ChanW-1:0] tgt_lo = ChanZero;
  logic [ChanW-1:0] tgt_hi = ChanFull;
  bit no_idle = 1'b0;            // when set, neither side idles
  int unsigned mismatch_count = 0;
  int unsigned n_gather = 0;
  int unsigned n_transform = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  stim_row_t stim_table [NumDirected];

  rgb_min_max_contrast_stretch i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Gap length for either side: mostly short, now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Map each channel into the target range with the tracked min and max.
  // Signed arithmetic, division truncating toward zero, low 8 bits kept;
  // a channel with equal min and max passes through.
  function automatic rgb_t stretch_pixel(rgb_t px);
    rgb_t out;
    int span;
    int scale;
    int q;
    scale = int'(tgt_hi) - int'(tgt_lo);
    for (int c = 0; c < NumChan; c++) begin
      span = int'(chan_hi[c]) - int'(chan_lo[c]);
      if (span == 0) begin
        out[c] = px[c];
      end else begin
        q = (int'(px[c]) - int'(chan_lo[c])) * scale / span + int'(tgt_lo);
        out[c] = q[ChanW-1:0];
      end
    end
    return out;
  endfunction

  function automatic rgb_t rand_between(rgb_t lo, rgb_t hi);
    rgb_t v;
    for (int c = 0; c < NumChan; c++) v[c] = ChanW'($urandom_range(lo[c], hi[c]));
    return v;
  endfunction

  function automatic stim_row_t pix_row(logic op, logic fs, rgb_t px, logic known = 1'b0,
                                        rgb_t want = '0);
    stim_row_t r;
    r = '0;
    r.kind = RowPixel;
    r.op = op;
    r.fs = fs;
    r.px = px;
    r.known = known;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [ChanW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = RowWrite;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Offer one pixel, hold it until the transfer, then update the predictor.
  // Entered and left at a falling edge; valid stays high into the next call.
  task automatic send_pixel(logic op, logic fs, rgb_t px, logic known = 1'b0,
                            rgb_t want = '0);
    if (!no_idle && $urandom_range(0, 1) == 0) begin
      pix.valid = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.opcode = op;
    pix.frame_start = fs;
    pix.red_in = px[0];
    pix.green_in = px[1];
    pix.blue_in = px[2];
    do @(posedge clk_i); while (!pix.ready);
    if (op == OpGather) begin
      if (fs) begin
        chan_lo = {NumChan{ChanFull}};
        chan_hi = {NumChan{ChanZero}};
      end
      for (int c = 0; c < NumChan; c++) begin
        if (px[c] < chan_lo[c]) chan_lo[c] = px[c];
        if (px[c] > chan_hi[c]) chan_hi[c] = px[c];
      end
      n_gather++;
    end else begin
      stretched_q.insert(stretched_q.size(), known ? want : stretch_pixel(px));
      n_transform++;
    end
    @(negedge clk_i);
  endtask

  // Write one target register once the block has gone quiet.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ChanW-1:0] val);
    pix.valid = 1'b0;
    while (stretched_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgTargetLow) tgt_lo = val;
    else tgt_hi = val;
    n_writes++;
  endtask

  // One frame: mostly a gather pass over a random window per channel and a
  // transform pass, sometimes a burst of arbitrary items.
  task automatic run_frame();
    rgb_t wlo;
    rgb_t whi;
    rgb_t px;
    int unsigned hi;
    int unsigned w;
    int unsigned sel;
    int unsigned n;
    if ($urandom_range(0, 9) < 8) begin
      for (int c = 0; c < NumChan; c++) begin
        sel = $urandom_range(0, 9);
        w = (sel == 0) ? 0 : (sel < 6) ? $urandom_range(1, 40) : $urandom_range(41, 255);
        wlo[c] = ChanW'($urandom_range(0, 255));
        hi = wlo[c] + w;
        whi[c] = (hi > 255) ? ChanFull : hi[ChanW-1:0];
      end
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_pixel(OpGather, i == 0, rand_between(wlo, whi));
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        // mostly samples inside the gathered range, some anywhere
        if ($urandom_range(0, 4) == 0) px = (NumChan*ChanW)'($urandom);
        else px = rand_between(chan_lo, chan_hi);
        send_pixel(OpTransform, $urandom_range(0, 7) == 0, px);
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        px = (NumChan*ChanW)'($urandom);
        send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), px);
      end
    end
  endtask

  // Result sink: ready drops now and then for a random stretch.
  initial begin
    int unsigned stall;
    stall = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0 && !no_idle) begin
        res.ready = 1'b0;
        stall--;
      end else begin
        res.ready = 1'b1;
        stall = ($urandom_range(0, 7) == 0) ? gap_len() : 0;
      end
    end
  end

  // Compare every result transfer with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    rgb_t got;
    rgb_t want;
    if (rst_ni && res.valid && res.ready) begin
      got = {res.red_out, res.green_out, res.blue_out};
      if (stretched_q.size() == 0) begin
        $error("result transfer with no transform outstanding: %h", got);
        mismatch_count++;
      end else begin
        want = stretched_q.pop_front();
        n_checked++;
        for (int c = 0; c < NumChan; c++) begin
          if (got[c] !== want[c]) begin
            $error("%s mismatch: expected %0d, actual %0d",
                   (c == 0) ? "red_out" : (c == 1) ? "green_out" : "blue_out",
                   want[c], got[c]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("rgb_min_max_contrast_stretch test failed");
    $finish;
  end

  initial begin
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] hi;
    int unsigned phase;
    int unsigned sel;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgTargetLow;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.opcode = OpGather;
    pix.frame_start = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;

    // Directed table. Rows with a typed expectation can be read straight off
    // the formula; the others go through the predictor.
    stim_table = '{
      // transform before any gather: min 255, max 0, negative span
      pix_row(OpTransform, 1'b0, {8'd0, 8'd255, 8'd128}, 1'b1, {8'd255, 8'd0, 8'd127}),
      // start flag on a transform does nothing
      pix_row(OpTransform, 1'b1, {8'd255, 8'd255, 8'd255}, 1'b1, {8'd0, 8'd0, 8'd0}),
      // one-pixel frame: min equals max, samples pass through
      pix_row(OpGather, 1'b1, {8'd0, 8'd0, 8'd0}),
      pix_row(OpTransform, 1'b0, {8'd200, 8'd7, 8'd0}, 1'b1, {8'd200, 8'd7, 8'd0}),
      // full range on green and blue, 10..250 on red
      pix_row(OpGather, 1'b1, {8'd10, 8'd0, 8'd255}),
      pix_row(OpGather, 1'b0, {8'd250, 8'd255, 8'd0}),
      pix_row(OpTransform, 1'b0, {8'd10, 8'd0, 8'd255}, 1'b1, {8'd0, 8'd0, 8'd255}),
      pix_row(OpTransform, 1'b0, {8'd250, 8'd255, 8'd0}, 1'b1, {8'd255, 8'd255, 8'd0}),
      // red below its min, then above its max
      pix_row(OpTransform, 1'b0, {8'd0, 8'd128, 8'd77}),
      pix_row(OpTransform, 1'b0, {8'd255, 8'd64, 8'd200}),
      // gather without the start flag widens the red range
      pix_row(OpGather, 1'b0, {8'd255, 8'd1, 8'd254}),
      // target range collapsed at the top: every channel lands on 255
      cfg_row(CfgTargetLow, 8'd255),
      pix_row(OpTransform, 1'b0, {8'd37, 8'd200, 8'd3}, 1'b1, {8'd255, 8'd255, 8'd255}),
      // target high below target low: negative scale
      cfg_row(CfgTargetHigh, 8'd0),
      pix_row(OpTransform, 1'b0, {8'd0, 8'd255, 8'd10}),
      // target range collapsed at zero
      cfg_row(CfgTargetLow, 8'd0),
      pix_row(OpTransform, 1'b0, {8'd128, 8'd128, 8'd128}, 1'b1, {8'd0, 8'd0, 8'd0}),
      // flat frame passes through even with a zero scale
      pix_row(OpGather, 1'b1, {8'd77, 8'd77, 8'd77}),
      pix_row(OpTransform, 1'b0, {8'd1, 8'd254, 8'd77}, 1'b1, {8'd1, 8'd254, 8'd77}),
      cfg_row(CfgTargetHigh, 8'd255),
      pix_row(OpGather, 1'b0, {8'd200, 8'd76, 8'd78}),
      pix_row(OpTransform, 1'b0, {8'd200, 8'd77, 8'd76})
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == RowWrite) begin
        write_reg(stim_table[i].idx, stim_table[i].val);
      end else begin
        send_pixel(stim_table[i].op, stim_table[i].fs, stim_table[i].px,
                   stim_table[i].known, stim_table[i].want);
      end
    end

    // Random phases: a target setting (extremes first), then a few frames.
    phase = 0;
    while (n_gather + n_transform < NumDirected - 4 + RandomItems) begin
      case (phase)
        0: begin lo = 8'd0;   hi = 8'd255; end
        1: begin lo = 8'd255; hi = 8'd0;   end
        2: begin lo = 8'd0;   hi = 8'd0;   end
        3: begin lo = 8'd255; hi = 8'd255; end
        default: begin
          lo = ChanW'($urandom_range(0, 255));
          hi = ChanW'($urandom_range(0, 255));
        end
      endcase
      sel = (phase < 4) ? 2 : $urandom_range(0, 2);
      if (sel != 1) write_reg(CfgTargetLow, lo);
      if (sel != 0) write_reg(CfgTargetHigh, hi);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) run_frame();
      phase++;
    end

    // Drain: drop valid, wait for every owed result, then let the block settle.
    pix.valid = 1'b0;
    no_idle = 1'b0;
    while (stretched_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d gather and %0d transform transfers over %0d register writes.",
             n_gather, n_transform, n_writes);
    $display("Checked %0d stretched pixels, %0d field mismatches.", n_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("rgb_min_max_contrast_stretch test passed");
    end else begin
      $display("rgb_min_max_contrast_stretch test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/cms_pkg.sv
sv/cms_if.sv
sv/cms_div.sv
sv/rgb_min_max_contrast_stretch.sv
tb/sv/testbench.sv
